// ===== src/per_class_presence_debouncer_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the per-class presence debouncer
// Shared property templates, sampled on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef PER_CLASS_PRESENCE_DEBOUNCER_UNIT_DEFINES_SVH
`define PER_CLASS_PRESENCE_DEBOUNCER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCPD_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("pcpd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PCPD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pcpd assertion failed");

`endif

// ===== src/pcpd_pkg.sv =====
// ---------------------------------------------------------------------------
// pcpd_pkg
// Types, constants and time helpers shared by the presence debouncer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcpd_pkg;

  localparam int CLS_W       = 7;
  localparam int MAX_CLASSES = 1 << CLS_W;
  localparam int CONF_W      = 16;
  localparam int TIME_BITS   = 48;
  localparam int MS_W        = 20;
  localparam int ACT_W       = 8;
  localparam int US_W        = 30;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam int US_PER_MS   = 1000;
  localparam int ABSENCE_MS  = 500;
  // Whole elapsed ms above the grace window is the same as this many us or more.
  localparam logic [US_W-1:0] ABSENCE_US = US_W'((ABSENCE_MS + 1) * US_PER_MS);
  localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(80);

  // A backwards step smaller than one millisecond still counts as zero ms.
  localparam logic [TIME_BITS:0] NEG_FLOOR =
    (TIME_BITS+1)'(0) - (TIME_BITS+1)'(US_PER_MS - 1);

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_ACTIVE = 2'd1,
    REG_HOLD   = 2'd2,
    REG_COOL   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic             enable;
    logic [ACT_W-1:0] active_classes;
    logic [US_W-1:0]  hold_us;
    logic [US_W-1:0]  cool_us;
  } cfg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] presence_start;
    logic [TIME_BITS-1:0] last_seen;
    logic [TIME_BITS-1:0] last_event;
  } entry_t;

  // True when the truncated ms from then to now is non-negative and at least
  // the threshold, given in microseconds as a whole multiple of 1000.
  function automatic logic elapsed_reached(input logic [TIME_BITS-1:0] now,
                                           input logic [TIME_BITS-1:0] then,
                                           input logic [US_W-1:0]      thr_us);
    logic [TIME_BITS:0] diff;
    logic               res;
    diff = {1'b0, now} - {1'b0, then};
    if (diff[TIME_BITS]) begin
      res = (thr_us == '0) && (diff >= NEG_FLOOR);
    end else begin
      res = diff[TIME_BITS-1:0] >= TIME_BITS'(thr_us);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/pcpd_cfg.sv =====
// ---------------------------------------------------------------------------
// pcpd_cfg
// APB register file; keeps the hold and cooldown times also in microseconds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcpd_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pcpd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [pcpd_pkg::DATA_W-1:0] pwdata,
  output logic      [pcpd_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output pcpd_pkg::cfg_t                   cfg_o
);

  logic                          enable_q;
  logic [pcpd_pkg::ACT_W-1:0]    active_q;
  logic [pcpd_pkg::MS_W-1:0]     hold_ms_q;
  logic [pcpd_pkg::MS_W-1:0]     cool_ms_q;
  logic [pcpd_pkg::US_W-1:0]     hold_us_q;
  logic [pcpd_pkg::US_W-1:0]     cool_us_q;
  logic [pcpd_pkg::US_W-1:0]     wdata_us;
  logic                          wr_en;
  pcpd_pkg::reg_idx_e            reg_idx;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign reg_idx  = pcpd_pkg::reg_idx_e'(paddr[3:2]);
  assign wdata_us = pcpd_pkg::US_W'(pwdata[pcpd_pkg::MS_W-1:0]) *
                    pcpd_pkg::US_W'(pcpd_pkg::US_PER_MS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      active_q  <= pcpd_pkg::ACTIVE_RESET;
      hold_ms_q <= '0;
      cool_ms_q <= '0;
      hold_us_q <= '0;
      cool_us_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        pcpd_pkg::REG_ENABLE: enable_q <= pwdata[0];
        pcpd_pkg::REG_ACTIVE: active_q <= pwdata[pcpd_pkg::ACT_W-1:0];
        pcpd_pkg::REG_HOLD: begin
          hold_ms_q <= pwdata[pcpd_pkg::MS_W-1:0];
          hold_us_q <= wdata_us;
        end
        pcpd_pkg::REG_COOL: begin
          cool_ms_q <= pwdata[pcpd_pkg::MS_W-1:0];
          cool_us_q <= wdata_us;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pcpd_pkg::REG_ENABLE: prdata = pcpd_pkg::DATA_W'(enable_q);
      pcpd_pkg::REG_ACTIVE: prdata = pcpd_pkg::DATA_W'(active_q);
      pcpd_pkg::REG_HOLD:   prdata = pcpd_pkg::DATA_W'(hold_ms_q);
      pcpd_pkg::REG_COOL:   prdata = pcpd_pkg::DATA_W'(cool_ms_q);
      default:              prdata = '0;
    endcase
  end

  assign cfg_o.enable         = enable_q;
  assign cfg_o.active_classes = active_q;
  assign cfg_o.hold_us        = hold_us_q;
  assign cfg_o.cool_us        = cool_us_q;

endmodule

`default_nettype wire

// ===== src/pcpd_track.sv =====
// ---------------------------------------------------------------------------
// pcpd_track
// Per-class timestamp memory with read-modify-write and write forwarding.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "per_class_presence_debouncer_unit_defines.svh"

module pcpd_track (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire pcpd_pkg::cfg_t                 cfg_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [pcpd_pkg::CLS_W-1:0]     class_index_i,
  input  wire logic [pcpd_pkg::CONF_W-1:0]    confidence_i,
  input  wire logic [pcpd_pkg::TIME_BITS-1:0] time_us_i,
  input  wire logic                           out_free_i,
  output logic                                emit_o,
  output logic      [pcpd_pkg::CLS_W-1:0]     emit_class_o,
  output logic      [pcpd_pkg::CONF_W-1:0]    emit_conf_o
);

  pcpd_pkg::entry_t                  mem_q [pcpd_pkg::MAX_CLASSES];
  pcpd_pkg::entry_t                  rd_q;
  logic [pcpd_pkg::MAX_CLASSES-1:0]  vld_q;

  logic                              s1_valid_q;
  logic [pcpd_pkg::CLS_W-1:0]        s1_cls_q;
  logic [pcpd_pkg::CONF_W-1:0]       s1_conf_q;
  logic [pcpd_pkg::TIME_BITS-1:0]    s1_time_q;

  logic                              fwd_valid_q;
  logic [pcpd_pkg::CLS_W-1:0]        fwd_cls_q;
  pcpd_pkg::entry_t                  fwd_entry_q;

  logic                              accept;
  logic                              s1_go;
  logic                              tracked;
  logic                              present;
  logic                              wr_en;
  logic                              hold_ok;
  logic                              cool_ok;
  logic                              fire;
  logic [pcpd_pkg::TIME_BITS-1:0]    start_d;
  pcpd_pkg::entry_t                  cur;
  pcpd_pkg::entry_t                  entry_d;

  assign in_stall_o = s1_valid_q && !out_free_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_go      = s1_valid_q && out_free_i;

  // The memory read at transfer time misses a write made on that same edge;
  // the forwarding register covers it. Never-written classes read as zero.
  always_comb begin
    if (fwd_valid_q && (fwd_cls_q == s1_cls_q)) begin
      cur = fwd_entry_q;
    end else if (!vld_q[s1_cls_q]) begin
      cur = '0;
    end else begin
      cur = rd_q;
    end
  end

  assign tracked = cfg_i.enable && ({1'b0, s1_cls_q} < cfg_i.active_classes);
  assign present = (s1_conf_q != '0);
  assign start_d = (cur.presence_start == '0) ? s1_time_q : cur.presence_start;
  assign hold_ok = pcpd_pkg::elapsed_reached(s1_time_q, start_d, cfg_i.hold_us);
  assign cool_ok = (cur.last_event == '0) ||
                   pcpd_pkg::elapsed_reached(s1_time_q, cur.last_event, cfg_i.cool_us);
  assign fire    = present && hold_ok && cool_ok;

  always_comb begin
    entry_d = cur;
    if (present) begin
      entry_d.last_seen      = s1_time_q;
      entry_d.presence_start = start_d;
      if (fire) begin
        entry_d.last_event = s1_time_q;
      end
    end else if ((cur.presence_start != '0) && (cur.last_seen != '0) &&
                 pcpd_pkg::elapsed_reached(s1_time_q, cur.last_seen,
                                           pcpd_pkg::ABSENCE_US)) begin
      entry_d.presence_start = '0;
    end
  end

  assign wr_en        = s1_go && tracked;
  assign emit_o       = wr_en && fire;
  assign emit_class_o = s1_cls_q;
  assign emit_conf_o  = s1_conf_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q      <= mem_q[class_index_i];
      s1_cls_q  <= class_index_i;
      s1_conf_q <= confidence_i;
      s1_time_q <= time_us_i;
    end
    if (wr_en) begin
      mem_q[s1_cls_q] <= entry_d;
      fwd_cls_q       <= s1_cls_q;
      fwd_entry_q     <= entry_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (wr_en) begin
        fwd_valid_q     <= 1'b1;
        vld_q[s1_cls_q] <= 1'b1;
      end
    end
  end

  `PCPD_ASSERT_NEXT(a_fwd_tracks_write, wr_en,
                    fwd_valid_q && (fwd_cls_q == $past(s1_cls_q)))
  `PCPD_ASSERT_NEXT(a_valid_after_write, wr_en, vld_q[$past(s1_cls_q)])
  `PCPD_ASSERT_NEXT(a_event_time_stored, emit_o,
                    fwd_entry_q.last_event == $past(s1_time_q))
  `PCPD_ASSERT_NEXT(a_blocked_item_held, s1_valid_q && !out_free_i,
                    s1_valid_q && $stable(s1_cls_q) && $stable(s1_time_q))
  `PCPD_ASSERT_SAME(a_no_write_when_disabled, !cfg_i.enable, !wr_en)

endmodule

`default_nettype wire

// ===== src/per_class_presence_debouncer_unit.sv =====
// ---------------------------------------------------------------------------
// per_class_presence_debouncer_unit
// Per-class presence debouncer with minimum hold time and event cooldown.
// ---------------------------------------------------------------------------
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+---------------------------------
//  in       | sink      | in_valid_i / in_stall_o | class_index, confidence, time_us
//  out      | source    | out_valid_o/out_stall_i | event_class, event_confidence
//  config   | sink      | APB psel/penable/pready | enable, active_classes, hold, cool
//
//  One report is taken every cycle unless the input stalls; an event passes
//  through the timestamp memory read stage and then the output register.
//  Reset clears the per-class valid bits at once, so no clearing pass is needed.
//  A stalled output holds its event; the input stalls only while a report waits
//  in the memory stage behind a full, stalled output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module per_class_presence_debouncer_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pcpd_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [pcpd_pkg::DATA_W-1:0]    pwdata,
  output logic      [pcpd_pkg::DATA_W-1:0]    prdata,
  output logic                                pready,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [pcpd_pkg::CLS_W-1:0]     class_index_i,
  input  wire logic [pcpd_pkg::CONF_W-1:0]    confidence_i,
  input  wire logic [pcpd_pkg::TIME_BITS-1:0] time_us_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [pcpd_pkg::CLS_W-1:0]     event_class_o,
  output logic      [pcpd_pkg::CONF_W-1:0]    event_confidence_o
);

  pcpd_pkg::cfg_t                cfg;
  logic                          out_free;
  logic                          emit;
  logic [pcpd_pkg::CLS_W-1:0]    emit_class;
  logic [pcpd_pkg::CONF_W-1:0]   emit_conf;
  logic                          out_valid_q;
  logic [pcpd_pkg::CLS_W-1:0]    event_class_q;
  logic [pcpd_pkg::CONF_W-1:0]   event_conf_q;

  pcpd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pcpd_track u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .class_index_i (class_index_i),
    .confidence_i  (confidence_i),
    .time_us_i     (time_us_i),
    .out_free_i    (out_free),
    .emit_o        (emit),
    .emit_class_o  (emit_class),
    .emit_conf_o   (emit_conf)
  );

  // The output register can take a new event when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      event_class_q <= emit_class;
      event_conf_q  <= emit_conf;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign event_class_o      = event_class_q;
  assign event_confidence_o = event_conf_q;

endmodule

`default_nettype wire

// ===== sim/per_class_presence_debouncer_unit_test.sv =====
// ---------------------------------------------------------------------------
// per_class_presence_debouncer_unit_test
// Drives class reports into the presence debouncer and checks every event.
// A scoreboard keeps its own per-class timestamps and register copy, works
// out which reports must raise an event, and compares each event transfer
// in order. Directed reports cover the corner cases, then random phases run
// under several register settings with random gaps and output stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

class event_scoreboard;
  typedef struct packed {
    logic [pcpd_pkg::CLS_W-1:0]  cls;
    logic [pcpd_pkg::CONF_W-1:0] conf;
  } expected_event_t;

  logic [pcpd_pkg::TIME_BITS-1:0] start_us [pcpd_pkg::MAX_CLASSES];
  logic [pcpd_pkg::TIME_BITS-1:0] seen_us  [pcpd_pkg::MAX_CLASSES];
  logic [pcpd_pkg::TIME_BITS-1:0] fired_us [pcpd_pkg::MAX_CLASSES];

  logic                       tracking_on;
  logic [pcpd_pkg::ACT_W-1:0] class_limit;
  logic [pcpd_pkg::MS_W-1:0]  hold_ms;
  logic [pcpd_pkg::MS_W-1:0]  cool_ms;

  expected_event_t pending_events[$];
  int unsigned     mismatches;
  int unsigned     reports;
  int unsigned     ignored;
  int unsigned     events_checked;

  function new();
    foreach (start_us[i]) begin
      start_us[i] = '0;
      seen_us[i]  = '0;
      fired_us[i] = '0;
    end
    tracking_on    = 1'b0;
    class_limit    = pcpd_pkg::ACTIVE_RESET;
    hold_ms        = '0;
    cool_ms        = '0;
    mismatches     = 0;
    reports        = 0;
    ignored        = 0;
    events_checked = 0;
  endfunction

  function logic [31:0] reg_value(pcpd_pkg::reg_idx_e idx);
    case (idx)
      pcpd_pkg::REG_ENABLE: return 32'(tracking_on);
      pcpd_pkg::REG_ACTIVE: return 32'(class_limit);
      pcpd_pkg::REG_HOLD:   return 32'(hold_ms);
      default:              return 32'(cool_ms);
    endcase
  endfunction

  function void write_reg(pcpd_pkg::reg_idx_e idx, logic [31:0] value);
    case (idx)
      pcpd_pkg::REG_ENABLE: tracking_on = value[0];
      pcpd_pkg::REG_ACTIVE: class_limit = value[pcpd_pkg::ACT_W-1:0];
      pcpd_pkg::REG_HOLD:   hold_ms     = value[pcpd_pkg::MS_W-1:0];
      default:              cool_ms     = value[pcpd_pkg::MS_W-1:0];
    endcase
  endfunction

  // Whole milliseconds from earlier to now. A step back of a millisecond or
  // more is reported as negative; a smaller one counts as zero.
  function bit span_ms(logic [pcpd_pkg::TIME_BITS-1:0] now,
                       logic [pcpd_pkg::TIME_BITS-1:0] earlier,
                       output logic [pcpd_pkg::TIME_BITS-1:0] ms);
    if (now >= earlier) begin
      ms = (now - earlier) / pcpd_pkg::US_PER_MS;
      return 1'b0;
    end
    ms = '0;
    return ((earlier - now) / pcpd_pkg::US_PER_MS) != 0;
  endfunction

  function void note_report(logic [pcpd_pkg::CLS_W-1:0] cls,
                            logic [pcpd_pkg::CONF_W-1:0] conf,
                            logic [pcpd_pkg::TIME_BITS-1:0] now);
    logic [pcpd_pkg::TIME_BITS-1:0] ms;
    bit                             neg;
    expected_event_t                hit;
    reports++;
    if (!tracking_on || cls >= class_limit) begin
      ignored++;
      return;
    end
    if (conf == '0) begin
      if (start_us[cls] != '0 && seen_us[cls] != '0) begin
        neg = span_ms(now, seen_us[cls], ms);
        if (!neg && ms > pcpd_pkg::ABSENCE_MS) start_us[cls] = '0;
      end
      return;
    end
    seen_us[cls] = now;
    if (start_us[cls] == '0) start_us[cls] = now;
    neg = span_ms(now, start_us[cls], ms);
    if (neg || ms < hold_ms) return;
    // An unset last-event stamp means the cooldown does not apply yet.
    if (fired_us[cls] != '0) begin
      neg = span_ms(now, fired_us[cls], ms);
      if (neg || ms < cool_ms) return;
    end
    fired_us[cls] = now;
    hit.cls  = cls;
    hit.conf = conf;
    pending_events.push_back(hit);
  endfunction

  function void flag(string what, logic [63:0] expected, logic [63:0] actual);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, expected,
               actual);
    end
  endfunction

  function void check_event(logic [pcpd_pkg::CLS_W-1:0] cls,
                            logic [pcpd_pkg::CONF_W-1:0] conf);
    expected_event_t want;
    if (pending_events.size() == 0) begin
      flag("event with none pending (class, confidence)", '0, {cls, conf});
      return;
    end
    want = pending_events.pop_front();
    events_checked++;
    if (cls !== want.cls) flag("event_class", want.cls, cls);
    if (conf !== want.conf) flag("event_confidence", want.conf, conf);
  endfunction
endclass

module per_class_presence_debouncer_unit_test;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int SETTLE_CYCLES   = 8;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [pcpd_pkg::ADDR_W-1:0]    paddr;
  logic [pcpd_pkg::DATA_W-1:0]    pwdata;
  logic [pcpd_pkg::DATA_W-1:0]    prdata;
  logic                           pready;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [pcpd_pkg::CLS_W-1:0]     class_index_i;
  logic [pcpd_pkg::CONF_W-1:0]    confidence_i;
  logic [pcpd_pkg::TIME_BITS-1:0] time_us_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [pcpd_pkg::CLS_W-1:0]     event_class_o;
  logic [pcpd_pkg::CONF_W-1:0]    event_confidence_o;

  event_scoreboard                sb = new();
  int unsigned                    hold_off_asks = 0;
  int unsigned                    idle_cycles = 0;
  int unsigned                    settings_used = 0;
  int unsigned                    backward_steps = 0;
  logic [pcpd_pkg::TIME_BITS-1:0] stream_us = '0;

  per_class_presence_debouncer_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .class_index_i      (class_index_i),
    .confidence_i       (confidence_i),
    .time_us_i          (time_us_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .event_class_o      (event_class_o),
    .event_confidence_o (event_confidence_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [pcpd_pkg::CLS_W-1:0] pick_class();
    // Most reports hit a few hot classes so that presences build up.
    if ($urandom_range(0, 99) < 75) return pcpd_pkg::CLS_W'($urandom_range(0, 7));
    return pcpd_pkg::CLS_W'($urandom);
  endfunction

  function automatic logic [pcpd_pkg::CONF_W-1:0] pick_conf();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return '0;
    if (pick < 35) return '1;
    return pcpd_pkg::CONF_W'($urandom_range(1, 65535));
  endfunction

  function automatic logic [pcpd_pkg::TIME_BITS-1:0] advance_time();
    int unsigned                    pick;
    logic [pcpd_pkg::TIME_BITS-1:0] step;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      step = pcpd_pkg::TIME_BITS'($urandom_range(0, 150000));
    end else if (pick < 80) begin
      step = pcpd_pkg::TIME_BITS'($urandom_range(400000, 700000));
    end else if (pick < 85) begin
      step = {8'd0, 8'($urandom), 32'($urandom)};
    end else begin
      step = (pick < 93) ? pcpd_pkg::TIME_BITS'($urandom_range(0, 999))
                         : pcpd_pkg::TIME_BITS'($urandom_range(1000, 300000));
      if (stream_us >= step) begin
        stream_us = stream_us - step;
        backward_steps++;
      end
      return stream_us;
    end
    stream_us = stream_us + step;
    return stream_us;
  endfunction

  task automatic apb_xfer(input bit wr, input pcpd_pkg::reg_idx_e idx,
                          input logic [pcpd_pkg::DATA_W-1:0] wdata,
                          output logic [pcpd_pkg::DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= pcpd_pkg::ADDR_W'(4 * int'(idx));
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(input pcpd_pkg::reg_idx_e idx);
    logic [pcpd_pkg::DATA_W-1:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== sb.reg_value(idx)) sb.flag(idx.name(), sb.reg_value(idx), rd);
  endtask

  task automatic set_reg(input pcpd_pkg::reg_idx_e idx,
                         input logic [pcpd_pkg::DATA_W-1:0] value);
    logic [pcpd_pkg::DATA_W-1:0] unused;
    apb_xfer(1'b1, idx, value, unused);
    sb.write_reg(idx, value);
    check_reg(idx);
  endtask

  task automatic apply_setting(input logic en, input int unsigned act, input int unsigned hold,
                               input int unsigned cool);
    set_reg(pcpd_pkg::REG_ENABLE, pcpd_pkg::DATA_W'(en));
    set_reg(pcpd_pkg::REG_ACTIVE, pcpd_pkg::DATA_W'(act));
    set_reg(pcpd_pkg::REG_HOLD, pcpd_pkg::DATA_W'(hold));
    set_reg(pcpd_pkg::REG_COOL, pcpd_pkg::DATA_W'(cool));
    settings_used++;
  endtask

  task automatic send_report(input logic [pcpd_pkg::CLS_W-1:0] cls,
                             input logic [pcpd_pkg::CONF_W-1:0] conf,
                             input logic [pcpd_pkg::TIME_BITS-1:0] t);
    in_valid_i    <= 1'b1;
    class_index_i <= cls;
    confidence_i  <= conf;
    time_us_i     <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_report(cls, conf, t);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Reports that raise no event may still be in flight when the queue runs
  // dry, so a few more cycles pass before anything else is touched.
  task automatic drain_events();
    in_valid_i <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic en, input int unsigned act, input int unsigned hold,
                           input int unsigned cool, input int unsigned items,
                           input logic [pcpd_pkg::TIME_BITS-1:0] base_us);
    int unsigned gap_pct;
    int unsigned n;
    apply_setting(en, act, hold, cool);
    stream_us = base_us;
    gap_pct   = 0;
    for (n = 0; n < items; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 50;
        endcase
      end
      send_report(pick_class(), pick_conf(), advance_time());
      if ($urandom_range(0, 99) < gap_pct) idle_sender(gap_len());
    end
    drain_events();
  endtask

  // Output side: random stalls, plus one long hold-off when the stimulus
  // asks for it so that the pipeline fills and the input stalls.
  initial begin : event_sink_pacing
    int unsigned stall_left;
    int unsigned burst_left;
    int unsigned stall_pct;
    int unsigned served;
    stall_left = 0;
    burst_left = 0;
    stall_pct  = 0;
    served     = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (served != hold_off_asks) begin
        served     = hold_off_asks;
        stall_left = HOLD_OFF_CYCLES;
      end else if (stall_left == 0) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(30, 150);
          case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 10;
            default: stall_pct = 40;
          endcase
        end
        burst_left--;
        if ($urandom_range(0, 99) < stall_pct) stall_left = gap_len();
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_event(event_class_o, event_confidence_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int                             k;
    logic [pcpd_pkg::TIME_BITS-1:0] t;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid_i    <= 1'b0;
    class_index_i <= '0;
    confidence_i  <= '0;
    time_us_i     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (k = 0; k < 4; k++) check_reg(pcpd_pkg::reg_idx_e'(k));

    // Still disabled after reset: this report must leave no trace.
    send_report(7'd3, 16'h00FF, 48'd1000);
    drain_events();

    apply_setting(1'b1, 80, 0, 0);
    send_report(7'd0, 16'hFFFF, 48'd0);      // presence starting at time zero
    send_report(7'd0, 16'd1, 48'd500);       // zero start reads as unset, restarts
    send_report(7'd0, 16'd2, 48'd1200);
    send_report(7'd0, 16'd3, 48'd700);       // step back under a millisecond
    send_report(7'd79, 16'h8000, 48'd2000);  // last tracked class
    send_report(7'd80, 16'h1234, 48'd2100);  // just past the active range
    send_report(7'd127, 16'hFFFF, 48'd2200);
    send_report(7'd5, 16'd0, 48'd3000);      // absent, nothing to end
    send_report(7'd5, 16'd9, 48'd5000);
    send_report(7'd5, 16'd10, 48'd3500);     // presence start now lies in the future
    send_report(7'd5, 16'd0, 48'd503500);    // exactly 500 ms unseen keeps presence
    send_report(7'd5, 16'd0, 48'd1000);      // absence measured backwards
    send_report(7'd5, 16'd0, 48'd504500);    // 501 ms unseen ends it
    send_report(7'd5, 16'd7, 48'd504600);
    send_report(7'd1, 16'd1, '1);
    send_report(7'd1, 16'd0, 48'd0);
    send_report(7'd1, 16'd2, 48'd0);
    drain_events();

    apply_setting(1'b1, 80, 2, 3);
    send_report(7'd2, 16'd100, 48'd10000);
    send_report(7'd2, 16'd101, 48'd11999);   // hold not yet reached
    send_report(7'd2, 16'd102, 48'd12000);   // hold reached, never sent before
    send_report(7'd2, 16'd103, 48'd14999);   // cooldown still running
    send_report(7'd2, 16'd104, 48'd15000);
    drain_events();

    // Long output hold-off while fresh classes keep arriving back to back.
    apply_setting(1'b1, 128, 0, 0);
    hold_off_asks <= hold_off_asks + 1;
    t = 48'd10_000_000;
    for (k = 0; k < 16; k++) begin
      t = t + 48'd1500;
      send_report(pcpd_pkg::CLS_W'(32 + k), pcpd_pkg::CONF_W'(k + 1), t);
    end
    drain_events();

    run_phase(1'b1, 128, 0, 0, 100, 48'd20_000_000);
    run_phase(1'b1, 80, 5, 10, 120, 48'd0);
    run_phase(1'b1, 128, 50, 0, 100, 48'd40_000_000);
    run_phase(1'b1, 20, 0, 200, 100, 48'd90_000_000);
    run_phase(1'b0, 128, 0, 0, 30, 48'd95_000_000);
    run_phase(1'b1, 0, 0, 0, 20, 48'd96_000_000);
    run_phase(1'b1, 128, 1048575, 1048575, 40, 48'd100_000_000);
    run_phase(1'b1, 1, 0, 1048575, 40, 48'd200_000_000);
    run_phase(1'b1, 128, 20, 30, 100, 48'hFFFF_FF00_0000);

    $display("Covered %0d reports (%0d ignored) and %0d events over %0d register settings.",
             sb.reports, sb.ignored, sb.events_checked, settings_used);
    $display("Time stepped back %0d times; one %0d-cycle output hold-off; %0d mismatches.",
             backward_steps, HOLD_OFF_CYCLES, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_events.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
